/* hdl/teq_pkg.sv */
package teq_pkg;

  localparam int QueueDepthDef = 32;
  localparam int ClientBitsDef = 8;
  localparam int UsecW         = 20;
  localparam logic [UsecW-1:0] UsecPerSec = 20'd1000000;

  typedef enum logic [1:0] {
    K_ADD           = 2'd0,
    K_CANCEL_MSG    = 2'd1,
    K_CANCEL_CLIENT = 2'd2,
    K_TICK          = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_SCHEDULED = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_NULL      = 3'd2,
    ST_FULL      = 3'd3,
    ST_DONE      = 3'd4
  } status_e;

  // classification of a queued command
  typedef struct packed {
    kind_e kind;
    logic  null_client;
  } cls_t;

  // handshake between front and back
  typedef struct packed {
    logic valid;
    cls_t cls;
  } head_t;

endpackage

/* hdl/teq_fifo.sv */
module teq_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic         full_o,
  output logic         empty_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0] mem_q [2];
  logic         wp_q, wp_d, rp_q, rp_d;
  logic [1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  always_comb begin
    wp_d  = push_i ? ~wp_q : wp_q;
    rp_d  = pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

/* hdl/teq_front.sv */
module teq_front
  import teq_pkg::*;
#(
  parameter int CB = ClientBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    kind_i,
  input  logic [CB-1:0] client_id_i,
  input  logic [31:0]   message_i,
  input  logic [31:0]   time_value_i,
  input  logic          absolute_i,
  input  logic [31:0]   clock_now_i,
  input  logic          pop_i,
  output head_t         head_o,
  output logic [CB-1:0] client_o,
  output logic [31:0]   message_o,
  output logic [31:0]   due_o,
  output logic [31:0]   now_o
);

  localparam int W = $bits(cls_t) + CB + 96;

  logic         full, empty, push;
  logic [31:0]  due;
  cls_t         cls_in, cls_out;
  logic [W-1:0] wdata, rdata;

  assign due                = absolute_i ? time_value_i : time_value_i + clock_now_i;
  assign cls_in.kind        = kind_e'(kind_i);
  assign cls_in.null_client = (client_id_i == '0);
  assign push               = start && !full;
  assign busy               = full;
  assign wdata              = {cls_in, client_id_i, message_i, due, clock_now_i};

  teq_fifo #(.W(W)) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (wdata),
    .pop_i  (pop_i),
    .full_o (full),
    .empty_o(empty),
    .data_o (rdata)
  );

  assign {cls_out, client_o, message_o, due_o, now_o} = rdata;
  assign head_o.valid = !empty;
  assign head_o.cls   = cls_out;

endmodule

/* hdl/teq_back.sv */
module teq_back
  import teq_pkg::*;
#(
  parameter int DEPTH = QueueDepthDef,
  parameter int CB    = ClientBitsDef,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  head_t            head_i,
  input  logic [CB-1:0]    client_i,
  input  logic [31:0]      message_i,
  input  logic [31:0]      due_i,
  input  logic [31:0]      now_i,
  output logic             pop_o,
  output logic             result_valid_o,
  output logic [2:0]       status_o,
  output logic             fired_o,
  output logic [CB-1:0]    event_client_o,
  output logic [31:0]      event_message_o,
  output logic [31:0]      event_time_o,
  output logic             last_o,
  output logic [CNT_W-1:0] entry_count_o,
  output logic [52:0]      until_next_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_CALC   = 3'd2;
  localparam logic [2:0] S_MOVE   = 3'd3;
  localparam logic [2:0] S_APPEND = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  // event table, shift line read at slot 0 only
  logic [CB-1:0] ecl_q [DEPTH];
  logic [CB-1:0] ecl_d [DEPTH];
  logic [31:0]   emsg_q [DEPTH];
  logic [31:0]   emsg_d [DEPTH];
  logic [31:0]   edue_q [DEPTH];
  logic [31:0]   edue_d [DEPTH];

  logic [2:0]       state_q, state_d;
  kind_e            kind_q, kind_d;
  logic             null_q, null_d;
  logic [CB-1:0]    ccl_q, ccl_d;
  logic [31:0]      cmsg_q, cmsg_d, cdue_q, cdue_d, cnow_q, cnow_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, n_q, n_d, t_q, t_d, o_q, o_d;
  logic [CNT_W-1:0] pos_q, pos_d, k_q, k_d, last_q, last_d;
  logic             any_q, any_d, dup_q, dup_d;
  logic             rest_v_q, rest_v_d, first_v_q, first_v_d;
  logic [31:0]      rest_due_q, rest_due_d, first_due_q, first_due_d;
  logic [52:0]      next_q, next_d;
  status_e          st_q, st_d;
  logic [31:0]      etime_q, etime_d;

  logic             rv_q, rv_d, rfired_q, rfired_d, rlast_q, rlast_d;
  status_e          rstatus_q, rstatus_d;
  logic [CB-1:0]    rcl_q, rcl_d;
  logic [31:0]      rmsg_q, rmsg_d, rtime_q, rtime_d;

  logic [CB-1:0]    hcl;
  logic [31:0]      hmsg, hdue;
  logic             keep, ins, nd_v;
  logic [31:0]      nd_due, nd_diff;
  logic [CNT_W-1:0] fin;
  logic [CNT_W:0]   wpos;
  logic [CNT_W:0]   wpos1;
  logic [51:0]      prod;

  logic             shift_en, wa_en, wb_en, wa_head;
  logic [IDX_W-1:0] wa_idx, wb_idx;

  assign hcl  = ecl_q[0];
  assign hmsg = emsg_q[0];
  assign hdue = edue_q[0];

  // landing slot so that the item ends at index o once the pass completes
  assign wpos  = {1'b0, o_q} + {1'b0, n_q} - {1'b0, t_q} - 1'b1;
  assign wpos1 = wpos + 1'b1;

  always_comb begin
    keep = 1'b1;
    if (kind_q == K_CANCEL_MSG && hcl == ccl_q && hmsg == cmsg_q) keep = 1'b0;
    if (kind_q == K_CANCEL_CLIENT && hcl == ccl_q) keep = 1'b0;
  end

  // finishing decisions taken after the scan
  always_comb begin
    ins    = (kind_q == K_ADD) && !null_q && !dup_q && (o_q < CNT_W'(DEPTH));
    fin    = o_q;
    nd_v   = first_v_q;
    nd_due = first_due_q;
    if (kind_q == K_ADD) begin
      fin    = ins ? o_q + 1'b1 : o_q;
      nd_v   = ins || first_v_q;
      nd_due = (ins && (pos_q == '0 || !first_v_q)) ? cdue_q : first_due_q;
    end else if (kind_q == K_TICK) begin
      fin    = o_q - k_q;
      nd_v   = rest_v_q;
      nd_due = rest_due_q;
    end
    nd_diff = nd_due - cnow_q;
    prod    = nd_diff * UsecPerSec;
  end

  always_comb begin
    state_d = state_q;
    kind_d = kind_q; null_d = null_q; ccl_d = ccl_q;
    cmsg_d = cmsg_q; cdue_d = cdue_q; cnow_d = cnow_q;
    cnt_d = cnt_q; n_d = n_q; t_d = t_q; o_d = o_q;
    pos_d = pos_q; k_d = k_q; last_d = last_q;
    any_d = any_q; dup_d = dup_q;
    rest_v_d = rest_v_q; rest_due_d = rest_due_q;
    first_v_d = first_v_q; first_due_d = first_due_q;
    next_d = next_q; st_d = st_q; etime_d = etime_q;
    rv_d = 1'b0; rfired_d = rfired_q; rlast_d = rlast_q; rstatus_d = rstatus_q;
    rcl_d = rcl_q; rmsg_d = rmsg_q; rtime_d = rtime_q;
    pop_o = 1'b0;
    shift_en = 1'b0; wa_en = 1'b0; wb_en = 1'b0; wa_head = 1'b0;
    wa_idx = wpos[IDX_W-1:0];
    wb_idx = wpos1[IDX_W-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          kind_d = head_i.cls.kind; null_d = head_i.cls.null_client;
          ccl_d = client_i; cmsg_d = message_i; cdue_d = due_i; cnow_d = now_i;
          n_d = cnt_q; t_d = '0; o_d = '0; pos_d = '0; k_d = '0; last_d = '0;
          any_d = 1'b0; dup_d = 1'b0; rest_v_d = 1'b0; first_v_d = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (t_q == n_q) begin
          state_d = S_CALC;
        end else begin
          shift_en = 1'b1;
          t_d = t_q + 1'b1;
          if (keep) begin
            wa_en = 1'b1; wa_head = 1'b1;
            o_d = o_q + 1'b1;
            if (!first_v_q) begin
              first_v_d = 1'b1; first_due_d = hdue;
            end
          end
          if (hdue == cdue_q && hcl == ccl_q && hmsg == cmsg_q) dup_d = 1'b1;
          if (hdue < cdue_q) pos_d = pos_q + 1'b1;
          if (hdue <= cnow_q) begin
            k_d = k_q + 1'b1;
            if (hcl != '0) begin
              any_d = 1'b1; last_d = t_q;
            end
          end else if (!rest_v_q) begin
            rest_v_d = 1'b1; rest_due_d = hdue;
          end
        end
      end
      S_CALC: begin
        cnt_d = fin;
        n_d = o_q; t_d = '0; o_d = '0;
        if (!nd_v) next_d = '1;
        else if (nd_due < cnow_q) next_d = '0;
        else next_d = {1'b0, prod};
        st_d = ST_DONE; etime_d = '0;
        if (kind_q == K_ADD) begin
          etime_d = null_q ? 32'd0 : cdue_q;
          if (null_q) st_d = ST_NULL;
          else if (dup_q) st_d = ST_DUPLICATE;
          else if (!ins) st_d = ST_FULL;
          else st_d = ST_SCHEDULED;
        end
        if (kind_q == K_TICK) state_d = (k_q == '0) ? S_RESULT : S_MOVE;
        else if (ins) state_d = (pos_q == o_q) ? S_APPEND : S_MOVE;
        else state_d = S_RESULT;
      end
      S_MOVE: begin
        if (kind_q == K_TICK) begin
          if (t_q == k_q) begin
            state_d = any_q ? S_IDLE : S_RESULT;
          end else begin
            // expired prefix leaves the table one per cycle
            shift_en = 1'b1;
            t_d = t_q + 1'b1;
            if (hcl != '0) begin
              rv_d = 1'b1; rfired_d = 1'b1; rlast_d = (t_q == last_q);
              rstatus_d = ST_DONE; rcl_d = hcl; rmsg_d = hmsg; rtime_d = hdue;
            end
          end
        end else if (t_q == n_q) begin
          state_d = S_RESULT;
        end else begin
          shift_en = 1'b1;
          t_d = t_q + 1'b1;
          wa_en = 1'b1;
          if (t_q == pos_q) begin
            wb_en = 1'b1;
            o_d = o_q + 2'd2;
          end else begin
            wa_head = 1'b1;
            o_d = o_q + 1'b1;
          end
        end
      end
      S_APPEND: begin
        wa_en = 1'b1;
        wa_idx = n_q[IDX_W-1:0];
        state_d = S_RESULT;
      end
      S_RESULT: begin
        rv_d = 1'b1; rfired_d = 1'b0; rlast_d = 1'b1; rstatus_d = st_q;
        rcl_d = '0; rmsg_d = '0; rtime_d = etime_q;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ecl_d = ecl_q; emsg_d = emsg_q; edue_d = edue_q;
    if (shift_en) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        ecl_d[i] = ecl_q[i+1]; emsg_d[i] = emsg_q[i+1]; edue_d[i] = edue_q[i+1];
      end
    end
    if (wa_en) begin
      ecl_d[wa_idx]  = wa_head ? hcl : ccl_q;
      emsg_d[wa_idx] = wa_head ? hmsg : cmsg_q;
      edue_d[wa_idx] = wa_head ? hdue : cdue_q;
    end
    if (wb_en) begin
      ecl_d[wb_idx] = hcl; emsg_d[wb_idx] = hmsg; edue_d[wb_idx] = hdue;
    end
  end

  always_ff @(posedge clk_i) begin
    ecl_q <= ecl_d; emsg_q <= emsg_d; edue_q <= edue_d;
    kind_q <= kind_d; null_q <= null_d; ccl_q <= ccl_d;
    cmsg_q <= cmsg_d; cdue_q <= cdue_d; cnow_q <= cnow_d;
    n_q <= n_d; t_q <= t_d; o_q <= o_d; pos_q <= pos_d; k_q <= k_d; last_q <= last_d;
    any_q <= any_d; dup_q <= dup_d;
    rest_v_q <= rest_v_d; rest_due_q <= rest_due_d;
    first_v_q <= first_v_d; first_due_q <= first_due_d;
    next_q <= next_d; st_q <= st_d; etime_q <= etime_d;
    rfired_q <= rfired_d; rlast_q <= rlast_d; rstatus_q <= rstatus_d;
    rcl_q <= rcl_d; rmsg_q <= rmsg_d; rtime_q <= rtime_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
    end
  end

  assign result_valid_o  = rv_q;
  assign status_o        = rstatus_q;
  assign fired_o         = rfired_q;
  assign event_client_o  = rcl_q;
  assign event_message_o = rmsg_q;
  assign event_time_o    = rtime_q;
  assign last_o          = rlast_q;
  assign entry_count_o   = cnt_q;
  assign until_next_o    = next_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("pending count above depth");

  a_scan_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> o_q <= t_q)
    else $error("scan wrote more entries than it read");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q && !rfired_q |-> rlast_q)
    else $error("non-event result not marked last");

  a_status_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q && rstatus_q != ST_DONE |-> $past(state_q) == S_RESULT)
    else $error("add status emitted outside result state");

endmodule

/* hdl/timer_event_queue_core.sv */
// channel   | ports                                        | flow
// ----------+----------------------------------------------+-----------------------------
// command   | start, busy, kind_i .. clock_now_i            | beat when start && !busy
// result    | result_valid_o, status_o .. until_next_o      | one-cycle strobe, no stall
//
// the back scans all pending events, then decides; cancel, an add that stores nothing
// and a tick with nothing due go to the result; a tick moves its due events out, and a
// result follows only when none of them has a client; an inserting add appends or makes
// a move pass; the table is a shift line moving one entry per cycle
// the front takes a beat into a two-deep queue while the back is still working
// reset clears the queue, the pending count and the sequencer; table contents
// are only read below the count
// results cannot be held off: each is on the ports for exactly one cycle
module timer_event_queue_core
  import teq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDef,
  parameter int CLIENT_BITS = ClientBitsDef,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             kind_i,
  input  logic [CLIENT_BITS-1:0] client_id_i,
  input  logic signed [31:0]     message_i,
  input  logic [31:0]            time_value_i,
  input  logic                   absolute_i,
  input  logic [31:0]            clock_now_i,
  output logic                   result_valid_o,
  output logic [2:0]             status_o,
  output logic                   fired_o,
  output logic [CLIENT_BITS-1:0] event_client_o,
  output logic signed [31:0]     event_message_o,
  output logic [31:0]            event_time_o,
  output logic                   last_o,
  output logic [CNT_W-1:0]       entry_count_o,
  output logic signed [52:0]     until_next_o
);

  head_t                  head;
  logic                   pop;
  logic [CLIENT_BITS-1:0] q_client;
  logic [31:0]            q_msg, q_due, q_now;
  logic [31:0]            ev_msg;
  logic [52:0]            nxt;

  // front: relative due time resolved and null client flagged at the beat
  teq_front #(.CB(CLIENT_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .kind_i      (kind_i),
    .client_id_i (client_id_i),
    .message_i   (message_i),
    .time_value_i(time_value_i),
    .absolute_i  (absolute_i),
    .clock_now_i (clock_now_i),
    .pop_i       (pop),
    .head_o      (head),
    .client_o    (q_client),
    .message_o   (q_msg),
    .due_o       (q_due),
    .now_o       (q_now)
  );

  // back: scan pass, then a move pass when needed, over the sorted table
  teq_back #(.DEPTH(QUEUE_DEPTH), .CB(CLIENT_BITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .client_i       (q_client),
    .message_i      (q_msg),
    .due_i          (q_due),
    .now_i          (q_now),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .fired_o        (fired_o),
    .event_client_o (event_client_o),
    .event_message_o(ev_msg),
    .event_time_o   (event_time_o),
    .last_o         (last_o),
    .entry_count_o  (entry_count_o),
    .until_next_o   (nxt)
  );

  assign event_message_o = ev_msg;
  assign until_next_o    = nxt;

endmodule

/* tb/teq_checker.sv */
module teq_checker
  import teq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         kind_i,
  input  logic [7:0]         client_id_i,
  input  logic signed [31:0] message_i,
  input  logic [31:0]        time_value_i,
  input  logic               absolute_i,
  input  logic [31:0]        clock_now_i,
  input  logic               result_valid_o,
  input  logic [2:0]         status_o,
  input  logic               fired_o,
  input  logic [7:0]         event_client_o,
  input  logic signed [31:0] event_message_o,
  input  logic [31:0]        event_time_o,
  input  logic               last_o,
  input  logic [5:0]         entry_count_o,
  input  logic signed [52:0] until_next_o,
  output int                 fail_count,
  output int                 waiting_beats
);

  typedef struct packed {
    logic [2:0]  status;
    logic        fired;
    logic [7:0]  ev_client;
    logic [31:0] ev_message;
    logic [31:0] ev_time;
    logic        last;
    logic [5:0]  count;
    logic [52:0] to_next;
  } timer_beat_t;

  localparam int Depth = 32;

  logic [7:0]  tbl_client [Depth];
  logic [31:0] tbl_message[Depth];
  logic [31:0] tbl_due    [Depth];
  int          tbl_count;

  timer_beat_t due_beats[$];
  int          fails;

  assign fail_count    = fails;
  assign waiting_beats = due_beats.size();

  function automatic timer_beat_t beat(status_e st, logic fi, logic [7:0] c,
                                       logic [31:0] m, logic [31:0] t);
    timer_beat_t b;
    b = '0;
    b.status     = st;
    b.fired      = fi;
    b.ev_client  = c;
    b.ev_message = m;
    b.ev_time    = t;
    return b;
  endfunction

  task automatic drop_entry(int pos);
    for (int i = pos; i + 1 < tbl_count; i++) begin
      tbl_client[i]  = tbl_client[i+1];
      tbl_message[i] = tbl_message[i+1];
      tbl_due[i]     = tbl_due[i+1];
    end
    tbl_count--;
  endtask

  // advance the table by one command and queue the beats it produces
  task automatic predict_command(kind_e k, logic [7:0] c, logic [31:0] m,
                                 logic [31:0] tv, logic ab, logic [31:0] now);
    timer_beat_t out[$];
    logic [31:0] due;
    logic        dup;
    int          pos;
    longint      delta;
    logic [52:0] nxt;
    due = ab ? tv : tv + now;
    case (k)
      K_ADD: begin
        if (c == 0) begin
          out.push_back(beat(ST_NULL, 0, 0, 0, 0));
        end else begin
          dup = 0;
          pos = 0;
          for (int i = 0; i < tbl_count; i++) begin
            if (tbl_due[i] == due && tbl_client[i] == c && tbl_message[i] == m) dup = 1;
            if (tbl_due[i] < due) pos = i + 1;
          end
          if (dup) begin
            out.push_back(beat(ST_DUPLICATE, 0, 0, 0, due));
          end else if (tbl_count >= Depth) begin
            out.push_back(beat(ST_FULL, 0, 0, 0, due));
          end else begin
            // new event goes ahead of others with the same due time
            for (int i = tbl_count; i > pos; i--) begin
              tbl_client[i]  = tbl_client[i-1];
              tbl_message[i] = tbl_message[i-1];
              tbl_due[i]     = tbl_due[i-1];
            end
            tbl_client[pos]  = c;
            tbl_message[pos] = m;
            tbl_due[pos]     = due;
            tbl_count++;
            out.push_back(beat(ST_SCHEDULED, 0, 0, 0, due));
          end
        end
      end
      K_CANCEL_MSG, K_CANCEL_CLIENT: begin
        for (int i = tbl_count - 1; i >= 0; i--)
          if (tbl_client[i] == c && (k == K_CANCEL_CLIENT || tbl_message[i] == m))
            drop_entry(i);
        out.push_back(beat(ST_DONE, 0, 0, 0, 0));
      end
      default: begin
        while (tbl_count > 0 && tbl_due[0] <= now) begin
          if (tbl_client[0] != 0)
            out.push_back(beat(ST_DONE, 1, tbl_client[0], tbl_message[0], tbl_due[0]));
          drop_entry(0);
        end
        if (out.size() == 0) out.push_back(beat(ST_DONE, 0, 0, 0, 0));
      end
    endcase
    if (tbl_count == 0) begin
      nxt = '1;
    end else if (tbl_due[0] < now) begin
      nxt = '0;
    end else begin
      delta = (longint'(tbl_due[0]) - longint'(now)) * 64'sd1000000;
      nxt   = delta[52:0];
    end
    foreach (out[i]) begin
      out[i].last    = (i == out.size() - 1);
      out[i].count   = tbl_count[5:0];
      out[i].to_next = nxt;
      due_beats.push_back(out[i]);
    end
  endtask

  timer_beat_t seen;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_count = 0;
      fails     = 0;
      due_beats.delete();
    end else begin
      if (start && !busy)
        predict_command(kind_e'(kind_i), client_id_i, message_i, time_value_i,
                        absolute_i, clock_now_i);
      if (result_valid_o) begin
        seen = {status_o, fired_o, event_client_o, event_message_o, event_time_o,
                last_o, entry_count_o, until_next_o};
        if (due_beats.size() == 0) begin
          fails++;
          if (fails <= 10) $display("checker: unexpected result beat %h", seen);
        end else if (seen !== due_beats[0]) begin
          fails++;
          if (fails <= 10)
            $display("checker: mismatch exp %h got %h", due_beats[0], seen);
          void'(due_beats.pop_front());
        end else begin
          void'(due_beats.pop_front());
        end
      end
    end
  end

endmodule

/* tb/tb_top.sv */
module tb_top;
  import teq_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         kind_i;
  logic [7:0]         client_id_i;
  logic signed [31:0] message_i;
  logic [31:0]        time_value_i;
  logic               absolute_i;
  logic [31:0]        clock_now_i;
  logic               result_valid_o;
  logic [2:0]         status_o;
  logic               fired_o;
  logic [7:0]         event_client_o;
  logic signed [31:0] event_message_o;
  logic [31:0]        event_time_o;
  logic               last_o;
  logic [5:0]         entry_count_o;
  logic signed [52:0] until_next_o;
  int                 fail_count;
  int                 waiting_beats;

  timer_event_queue_core dut (.*);
  teq_checker chk (.*);

  // 12 unit clock
  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog: ends the run with an error message past its cycle limit
  int cycles;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 300000) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  logic [31:0] now_clk;   // running clock carried by each beat
  int          burst_left;

  // present one command at the falling edge and hold it until taken
  task automatic issue(kind_e k, logic [7:0] c, logic [31:0] m, logic [31:0] tv,
                       logic ab, logic [31:0] now);
    logic was_busy;
    kind_i       = k;
    client_id_i  = c;
    message_i    = m;
    time_value_i = tv;
    absolute_i   = ab;
    clock_now_i  = now;
    start        = 1;
    forever begin
      was_busy = busy;   // busy only moves at the rising edge
      @(negedge clk_i);
      if (!was_busy) break;
    end
    // sender bursts with random gaps between them
    burst_left--;
    if (burst_left <= 0) begin
      start = 0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
  endtask

  logic [7:0]  rc;
  logic [31:0] rm, rt;
  int          pick;

  initial begin
    rst_ni = 0;
    start = 0;
    kind_i = K_TICK;
    client_id_i = 0;
    message_i = 0;
    time_value_i = 0;
    absolute_i = 0;
    clock_now_i = 0;
    burst_left = 4;
    now_clk = 100;
    repeat (12) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: empty table, null client, wrap, duplicate, equal due times
    issue(K_TICK, 0, 0, 0, 0, 0);
    issue(K_CANCEL_MSG, 5, 1, 0, 0, 0);
    issue(K_ADD, 0, 32'h7fffffff, 10, 0, 100);
    issue(K_ADD, 8'hff, 32'h80000000, 32'hffffffff, 1, 100);
    issue(K_ADD, 1, -1, 32'hfffffff0, 0, 32'h20);      // relative wraps to 0x10
    issue(K_ADD, 2, 7, 200, 1, 100);
    issue(K_ADD, 2, 7, 200, 1, 100);                   // duplicate
    issue(K_ADD, 3, 9, 100, 0, 100);                   // same due, goes first
    issue(K_ADD, 3, 10, 200, 1, 100);
    issue(K_CANCEL_MSG, 3, 10, 0, 0, 100);
    issue(K_CANCEL_MSG, 4, 10, 0, 0, 100);             // no match
    issue(K_TICK, 0, 0, 0, 0, 150);                    // overdue left behind
    issue(K_TICK, 0, 0, 0, 0, 200);
    issue(K_CANCEL_CLIENT, 8'hff, 0, 0, 0, 300);
    // fill the table and push one past full
    for (int i = 0; i < 33; i++)
      issue(K_ADD, 8'(i % 5 + 1), i, $urandom_range(0, 40), 0, 1000);
    issue(K_TICK, 0, 0, 0, 0, 32'hffffffff);           // drain all at once

    // random: mostly well-formed traffic on a slowly moving clock
    now_clk = 2000;
    for (int n = 0; n < 100; n++) begin
      pick = $urandom_range(0, 99);
      rc = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 4));
      rm = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 3);
      rt = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 30);
      if ($urandom_range(0, 19) == 0) now_clk = $urandom;
      else now_clk += $urandom_range(0, 4);
      if (pick < 50)
        issue(K_ADD, rc, rm, ($urandom_range(0, 3) == 0) ? now_clk + rt : rt,
              ($urandom_range(0, 3) == 0), now_clk);
      else if (pick < 62) issue(K_CANCEL_MSG, rc, rm, $urandom, $urandom, now_clk);
      else if (pick < 70) issue(K_CANCEL_CLIENT, rc, $urandom, $urandom, $urandom, now_clk);
      else issue(K_TICK, 8'($urandom), $urandom, $urandom, $urandom, now_clk);
    end
    start = 0;

    while (waiting_beats != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
    if (fail_count == 0 && waiting_beats == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
